/* hw/rtl/rmhv_pkg.sv */
// ----------------------------------------------------------------------------
// Rank magic hash validator package
// Shared widths, sequencer condition codes and control-word types.
// ----------------------------------------------------------------------------
package rmhv_pkg;

  // Hash and pattern sizing
  localparam int HashBits    = 7;
  localparam int NumPatterns = 1 << HashBits;
  localparam int BoardBits   = 64;
  localparam int SquareBits  = 6;
  localparam int StepBits    = 2;

  // Jump conditions: when the condition is true the sequencer jumps to the
  // target step, otherwise it advances to the next step.
  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_NO_IN     = 3'd1,
    COND_PAT_MORE  = 3'd2,
    COND_PIPE_BUSY = 3'd3,
    COND_OUT_FULL  = 3'd4
  } cond_t;

  // One microcode word
  typedef struct packed {
    cond_t                cond;
    logic [StepBits-1:0]  target;
    logic                 load;   // take an item, clear seen map (on advance)
    logic                 issue;  // issue one pattern (every cycle in step)
    logic                 emit;   // write the result register (on advance)
  } ucode_t;

  // Gated actions from sequencer to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic emit;
  } dp_ctrl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic pat_last;
    logic pipe_busy;
    logic out_full;
  } dp_stat_t;

  // Step addresses of the program
  localparam logic [StepBits-1:0] StepWait  = 2'd0;
  localparam logic [StepBits-1:0] StepIssue = 2'd1;
  localparam logic [StepBits-1:0] StepDrain = 2'd2;
  localparam logic [StepBits-1:0] StepEmit  = 2'd3;

endpackage

/* hw/rtl/rank_magic_hash_validator_top.sv */
// ----------------------------------------------------------------------------
// Rank magic hash validator
// Checks that a 64-bit multiplier hashes all 128 rank blocker boards of a
// square to distinct 7-bit buckets.
//
//   channel | ports                            | direction
//   --------+----------------------------------+----------
//   input   | in_valid in_stall in_square      | in
//           | in_magic                         |
//   result  | out_valid out_stall out_valid_res| out
//
// An item is accepted, then 128 patterns are issued (one per cycle into the
// multiply/bucket pipeline), then a drain step waits until the two bucket
// checks still in flight have left the pipeline, and a final step writes the
// result register. The sequencer handles one item at a time. Reset is
// synchronous, active low, and leaves the block ready to accept.
// A stalled result holds in its register while the next item is accepted;
// a new result waits in the final step until that register is free.
// ----------------------------------------------------------------------------
module rank_magic_hash_validator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rmhv_pkg::SquareBits-1:0] in_square,
  input  logic [rmhv_pkg::BoardBits-1:0]  in_magic,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_valid_res
);

  rmhv_pkg::dp_ctrl_t ctrl;
  rmhv_pkg::dp_stat_t stat;

  // Microcode sequencer
  rmhv_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_stall (in_stall)
  );

  // Hash datapath
  rmhv_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .in_square     (in_square),
    .in_magic      (in_magic),
    .out_stall     (out_stall),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_valid_res (out_valid_res)
  );

endmodule

/* hw/rtl/rmhv_sequencer.sv */
// ----------------------------------------------------------------------------
// Rank magic hash validator sequencer
// Step counter over a four-word microcode ROM with conditional jumps.
// ----------------------------------------------------------------------------
module rmhv_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  rmhv_pkg::dp_stat_t stat,
  output rmhv_pkg::dp_ctrl_t ctrl,
  output logic              in_stall
);

  logic [rmhv_pkg::StepBits-1:0] step_r;
  logic [rmhv_pkg::StepBits-1:0] step_nxt;
  rmhv_pkg::ucode_t              uw;
  logic                          hit;

  // Microcode ROM
  always_comb begin
    unique case (step_r)
      rmhv_pkg::StepWait:
        uw = '{cond: rmhv_pkg::COND_NO_IN, target: rmhv_pkg::StepWait,
               load: 1'b1, issue: 1'b0, emit: 1'b0};
      rmhv_pkg::StepIssue:
        uw = '{cond: rmhv_pkg::COND_PAT_MORE, target: rmhv_pkg::StepIssue,
               load: 1'b0, issue: 1'b1, emit: 1'b0};
      rmhv_pkg::StepDrain:
        uw = '{cond: rmhv_pkg::COND_PIPE_BUSY, target: rmhv_pkg::StepDrain,
               load: 1'b0, issue: 1'b0, emit: 1'b0};
      rmhv_pkg::StepEmit:
        uw = '{cond: rmhv_pkg::COND_OUT_FULL, target: rmhv_pkg::StepEmit,
               load: 1'b0, issue: 1'b0, emit: 1'b1};
      default:
        uw = '{cond: rmhv_pkg::COND_NEVER, target: rmhv_pkg::StepWait,
               load: 1'b0, issue: 1'b0, emit: 1'b0};
    endcase
  end

  // Evaluate the jump condition
  always_comb begin
    unique case (uw.cond)
      rmhv_pkg::COND_NEVER:     hit = 1'b0;
      rmhv_pkg::COND_NO_IN:     hit = !in_valid;
      rmhv_pkg::COND_PAT_MORE:  hit = !stat.pat_last;
      rmhv_pkg::COND_PIPE_BUSY: hit = stat.pipe_busy;
      rmhv_pkg::COND_OUT_FULL:  hit = stat.out_full;
      default:                  hit = 1'b0;
    endcase
  end

  // Jump or advance; the last step wraps to the first
  assign step_nxt = hit ? uw.target : step_r + 1'b1;

  // Gate the actions
  assign ctrl.load  = uw.load && !hit;
  assign ctrl.issue = uw.issue;
  assign ctrl.emit  = uw.emit && !hit;
  assign in_stall   = !uw.load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= rmhv_pkg::StepWait;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

/* hw/rtl/rmhv_datapath.sv */
// ----------------------------------------------------------------------------
// Rank magic hash validator datapath
// Pattern counter, rank board build, multiply, bucket select, seen map and
// result register.
// ----------------------------------------------------------------------------
module rmhv_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rmhv_pkg::dp_ctrl_t                  ctrl,
  input  logic [rmhv_pkg::SquareBits-1:0]     in_square,
  input  logic [rmhv_pkg::BoardBits-1:0]      in_magic,
  input  logic                                out_stall,
  output rmhv_pkg::dp_stat_t                  stat,
  output logic                                out_valid,
  output logic                                out_valid_res
);

  // Item registers
  logic [rmhv_pkg::SquareBits-1:0]  sq_r;
  logic [rmhv_pkg::BoardBits-1:0]   magic_r;
  logic [rmhv_pkg::HashBits-1:0]    pat_r;
  // Multiply stage
  logic                             v1_r;
  logic [rmhv_pkg::BoardBits-1:0]   prod_r;
  // Bucket stage
  logic                             v2_r;
  logic [rmhv_pkg::HashBits-1:0]    bucket_r;
  logic [rmhv_pkg::BoardBits-1:0]   shifted;
  // Seen map and verdict
  logic [rmhv_pkg::NumPatterns-1:0] seen_r;
  logic                             ok_r;
  // Result register
  logic                             out_valid_r;
  logic                             out_res_r;

  logic [7:0]                       rank_byte;
  logic [2:0]                       file;
  logic [2:0]                       rank_idx;

  assign file     = sq_r[2:0];
  assign rank_idx = sq_r[5:3];

  // Build the rank occupancy byte: squares above the file take pattern bits
  // from bit zero up, squares below the file take the remaining bits
  always_comb begin
    rank_byte = '0;
    for (int j = 0; j < 8; j++) begin
      if (3'(j) > file) begin
        rank_byte[j] = pat_r[3'(3'(j) - file - 3'd1)];
      end else if (3'(j) < file) begin
        rank_byte[j] = pat_r[3'(6 - j)];
      end
    end
  end

  // Move the product up to the board's rank and take the top hash bits
  assign shifted = prod_r << {rank_idx, 3'b000};

  assign stat.pat_last  = (pat_r == rmhv_pkg::HashBits'(rmhv_pkg::NumPatterns - 1));
  assign stat.pipe_busy = v1_r || v2_r;
  assign stat.out_full  = out_valid_r && out_stall;

  // Load item, advance patterns and the hash pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      pat_r <= '0;
    end else begin
      if (ctrl.load) begin
        sq_r    <= in_square;
        magic_r <= in_magic;
        pat_r   <= '0;
      end else if (ctrl.issue) begin
        pat_r <= pat_r + 1'b1;
      end
      v1_r     <= ctrl.issue;
      prod_r   <= magic_r * rmhv_pkg::BoardBits'(rank_byte);
      v2_r     <= v1_r;
      bucket_r <= shifted[rmhv_pkg::BoardBits-1 -: rmhv_pkg::HashBits];
    end
  end

  // Check and mark the bucket; clear the map per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      ok_r   <= 1'b1;
    end else if (ctrl.load) begin
      seen_r <= '0;
      ok_r   <= 1'b1;
    end else if (v2_r) begin
      if (seen_r[bucket_r]) begin
        ok_r <= 1'b0;
      end
      seen_r[bucket_r] <= 1'b1;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
      out_res_r   <= ok_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = out_res_r;

endmodule

/* hw/rtl/rmhv_checker.sv */
// ----------------------------------------------------------------------------
// Rank magic hash validator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module rmhv_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [rmhv_pkg::SquareBits-1:0] in_square,
  input logic [rmhv_pkg::BoardBits-1:0]  in_magic,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_valid_res
);

  // Reset empties the result register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An accepted item keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice in a row");

  // A result appears only while no item is being taken
  a_emit_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised during accept step");

  // A stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=>
      (in_valid && $stable(in_square) && $stable(in_magic)))
    else $error("stalled input changed");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_valid_res)))
    else $error("stalled result changed");

endmodule

bind rank_magic_hash_validator_top rmhv_checker u_rmhv_checker (.*);

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// Rank magic hash validator testbench
// Sends square/multiplier candidates and checks each collision-free verdict
// against an in-bench predictor or, for fixed directed rows, a typed
// verdict. A short directed table comes first: known perfect shifts, zero
// and all-ones multipliers, corner squares. Random candidates follow, most
// of them built from shift multipliers with a few flipped bits so that both
// verdicts show up often. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RandomItems = 1000;
  localparam int IdleLimit   = 4000;
  localparam int DrainCycles = 200;
  localparam int NumProbes   = 18;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic [rmhv_pkg::SquareBits-1:0] in_square;
  logic [rmhv_pkg::BoardBits-1:0]  in_magic;
  logic                            out_valid;
  logic                            out_stall;
  logic                            out_valid_res;

  // Directed row: a typed verdict is used only where fixed is set
  typedef struct packed {
    logic [rmhv_pkg::SquareBits-1:0] square;
    logic [rmhv_pkg::BoardBits-1:0]  magic;
    logic                            fixed;
    logic                            verdict;
  } probe_t;

  probe_t probes [NumProbes] = '{
    '{6'd0,  64'h0000_0000_0000_0000, 1'b1, 1'b0},  // zero multiplier collides
    '{6'd63, 64'h0000_0000_0000_0000, 1'b1, 1'b0},
    '{6'd0,  64'h0100_0000_0000_0000, 1'b1, 1'b1},  // file a shift to top bits
    '{6'd7,  64'h0200_0000_0000_0000, 1'b1, 1'b1},  // file h shift to top bits
    '{6'd8,  64'h0001_0000_0000_0000, 1'b1, 1'b1},
    '{6'd56, 64'h0000_0000_0000_0001, 1'b1, 1'b1},  // top rank already on top
    '{6'd63, 64'h0000_0000_0000_0002, 1'b1, 1'b1},
    '{6'd0,  64'h0000_0000_0000_0001, 1'b1, 1'b0},  // low boards stay in bucket 0
    '{6'd0,  64'h8000_0000_0000_0000, 1'b1, 1'b0},  // every product wraps to zero
    '{6'd0,  64'h0080_0000_0000_0000, 1'b0, 1'b0},
    '{6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
    '{6'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
    '{6'd27, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0},
    '{6'd36, 64'h5555_5555_5555_5555, 1'b0, 1'b0},
    '{6'd36, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0},
    '{6'd31, 64'h0102_0408_1020_4081, 1'b0, 1'b0},
    '{6'd32, 64'h8040_2010_0804_0201, 1'b0, 1'b0},
    '{6'd19, 64'h0000_4000_0000_0000, 1'b0, 1'b0}
  };

  bit perfect_q [$];   // pending verdicts, oldest first
  int mismatches;
  int idle_cycles;
  int burst_left;

  rank_magic_hash_validator_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_square     (in_square),
    .in_magic      (in_magic),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Build and hash each rank blocker board, stopping at the first repeated bucket
  function automatic bit rank_hash_is_perfect(
      input logic [rmhv_pkg::SquareBits-1:0] sq,
      input logic [rmhv_pkg::BoardBits-1:0]  mg);
    logic [rmhv_pkg::NumPatterns-1:0] hit;
    logic [rmhv_pkg::BoardBits-1:0]   board;
    logic [rmhv_pkg::BoardBits-1:0]   product;
    logic [rmhv_pkg::HashBits-1:0]    bucket;
    int                               east;
    int                               pos;
    bit                               ok;
    hit  = '0;
    ok   = 1'b1;
    east = 7 - int'(sq[2:0]);
    for (int p = 0; p < rmhv_pkg::NumPatterns && ok; p++) begin
      board = '0;
      for (int i = 0; i < 7; i++) begin
        // low pattern bits walk toward file h, the rest toward file a
        pos = (i < east) ? int'(sq) + i + 1 : int'(sq) - (i - east + 1);
        if (p[i]) board[pos] = 1'b1;
      end
      product = board * mg;
      bucket  = product[rmhv_pkg::BoardBits-1 -: rmhv_pkg::HashBits];
      if (hit[bucket]) ok = 1'b0;
      else hit[bucket] = 1'b1;
    end
    return ok;
  endfunction

  // Mostly shift multipliers with a few flipped bits, plus raw and sparse noise
  task automatic pick_candidate(output logic [rmhv_pkg::SquareBits-1:0] sq,
                                output logic [rmhv_pkg::BoardBits-1:0]  mg);
    int kind;
    int rank;
    int flips;
    kind = $urandom_range(0, 9);
    rank = $urandom_range(0, 7);
    if (kind < 3) begin
      sq = rmhv_pkg::SquareBits'($urandom_range(0, 63));
      mg = {$urandom, $urandom};
    end else if (kind < 9) begin
      if ($urandom_range(0, 1) == 1) begin
        sq = rmhv_pkg::SquareBits'(rank * 8);
        mg = 64'd1 << (56 - 8 * rank);
      end else begin
        sq = rmhv_pkg::SquareBits'(rank * 8 + 7);
        mg = 64'd1 << (57 - 8 * rank);
      end
      flips = $urandom_range(0, 3);
      repeat (flips) mg = mg ^ (64'd1 << $urandom_range(0, 63));
    end else begin
      sq = rmhv_pkg::SquareBits'($urandom_range(0, 63));
      mg = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    end
  endtask

  // Drive one item in bursts; record its verdict once accepted
  task automatic send_item(input logic [rmhv_pkg::SquareBits-1:0] sq,
                           input logic [rmhv_pkg::BoardBits-1:0]  mg,
                           input bit                              fixed,
                           input bit                              fixed_verdict);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
      burst_left = $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    in_square <= sq;
    in_magic  <= mg;
    do @(posedge clk); while (in_stall);
    perfect_q.push_back(fixed ? fixed_verdict : rank_hash_is_perfect(sq, mg));
  endtask

  // Reset, directed table, random candidates, drain and verdict
  initial begin : stimulus
    logic [rmhv_pkg::SquareBits-1:0] sq;
    logic [rmhv_pkg::BoardBits-1:0]  mg;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_square  = '0;
    in_magic   = '0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int k = 0; k < NumProbes; k++) begin
      send_item(probes[k].square, probes[k].magic, probes[k].fixed, probes[k].verdict);
    end
    for (int n = 0; n < RandomItems; n++) begin
      pick_candidate(sq, mg);
      send_item(sq, mg, 1'b0, 1'b0);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    wait (perfect_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver stall pattern: open, coin flip, light, or held shut
  initial begin : stall_gen
    int mode;
    int span;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 400);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_stall <= ($urandom_range(0, 7) == 0);
          end
          default: begin
            out_stall <= 1'b1;
          end
        endcase
      end
    end
  end

  // Check each accepted result item and track cycles without any handshake
  always @(posedge clk) begin
    bit want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (perfect_q.size() == 0) begin
          $error("valid_res: no item pending, actual %0b", out_valid_res);
          mismatches++;
        end else begin
          want = perfect_q.pop_front();
          if (out_valid_res !== want) begin
            $error("valid_res expected %0b actual %0b", want, out_valid_res);
            mismatches++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // Hold the run to a bound on silent cycles
  initial begin : watchdog
    wait (idle_cycles >= IdleLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* rank_magic_hash_validator_top.f */
hw/rtl/rmhv_pkg.sv
hw/rtl/rmhv_sequencer.sv
hw/rtl/rmhv_datapath.sv
hw/rtl/rank_magic_hash_validator_top.sv
hw/rtl/rmhv_checker.sv
tb/sv/tb_top.sv
